// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define SNL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SNL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/snl_pkg.sv =====
`default_nettype none
package snl_pkg;

   // Widths of the fields
   localparam int unsigned LEVEL_W  = 10;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned OFFSET_W = 9;

   // Sensor constants
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

   // Register reset values
   localparam logic [OFFSET_W-1:0] HYST_RESET = 9'd16;
   localparam logic [NIBBLE_W-1:0] GET_RESET  = 4'h3;
   localparam logic [NIBBLE_W-1:0] ACK_RESET  = 4'hE;

   // Request operation codes
   localparam logic [1:0] OP_STROBE = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_HYST = 2'd0;
   localparam logic [1:0] CSR_GET  = 2'd1;
   localparam logic [1:0] CSR_ACK  = 2'd2;

   // Bus phase sequence; even steps wait for a high strobe, odd for low
   typedef enum logic [3:0] {
      PH_WAIT_CMD  = 4'd0,
      PH_ANSWER    = 4'd1,
      PH_SETTLE_A  = 4'd2,
      PH_SEND_MID  = 4'd3,
      PH_SETTLE_B  = 4'd4,
      PH_SEND_LOW  = 4'd5,
      PH_SETTLE_C  = 4'd6,
      PH_SEND_ACK  = 4'd7,
      PH_SETTLE_D  = 4'd8,
      PH_RELEASE   = 4'd9
   } phase_type;

   // Request to the light tracker
   typedef struct packed {
      logic               update;
      logic               clear;
      logic [LEVEL_W-1:0] sample;
   } light_req_type;

   // One response
   typedef struct packed {
      logic                led_on;
      logic                bus_drive;
      logic [NIBBLE_W-1:0] bus_out;
      logic                command_valid;
      logic [NIBBLE_W-1:0] command;
      logic                flush_queue;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/snl_light.sv =====
`default_nettype none
module snl_light (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire snl_pkg::light_req_type        light_req,
   input  wire logic [snl_pkg::OFFSET_W-1:0]  hyst_offset,
   output logic                               led_next
);
   import snl_pkg::*;
   `include "assert_macros.svh"

   logic [LEVEL_W-1:0] high_ff, high_in;
   logic [LEVEL_W-1:0] low_ff, low_in;
   logic [LEVEL_W-1:0] mid_ff, mid_in;
   logic               led_ff, led_in;
   logic [LEVEL_W:0]   span_sum;
   logic [LEVEL_W:0]   sample_up;
   logic [LEVEL_W:0]   mid_up;

   // Track min, max and midpoint, then apply hysteresis on the LED; clear restarts min, max and midpoint
   always_comb begin
      high_in   = high_ff;
      low_in    = low_ff;
      mid_in    = mid_ff;
      led_in    = led_ff;
      span_sum  = '0;
      sample_up = {1'b0, light_req.sample} + {2'b00, hyst_offset};
      mid_up    = '0;
      if (light_req.clear) begin
         high_in = '0;
         low_in  = LEVEL_MAX;
         mid_in  = '0;
      end else if (light_req.update) begin
         if (light_req.sample > high_ff) begin
            high_in = light_req.sample;
         end
         if (light_req.sample < low_ff) begin
            low_in = light_req.sample;
         end
         span_sum = {1'b0, high_in} + {1'b0, low_in};
         if ((light_req.sample > high_ff) || (light_req.sample < low_ff)) begin
            mid_in = span_sum[LEVEL_W:1];
         end
         mid_up = {1'b0, mid_in} + {2'b00, hyst_offset};
         if (led_ff) begin
            if (sample_up < {1'b0, mid_in}) begin
               led_in = 1'b0;
            end
         end else begin
            if ({1'b0, light_req.sample} > mid_up) begin
               led_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= '0;
         low_ff  <= LEVEL_MAX;
         mid_ff  <= '0;
         led_ff  <= 1'b0;
      end else begin
         high_ff <= high_in;
         low_ff  <= low_in;
         mid_ff  <= mid_in;
         led_ff  <= led_in;
      end
   end

   assign led_next = led_in;

   `SNL_ASSERT(a_clear_restores_span, light_req.clear |=> (low_ff == LEVEL_MAX && high_ff == '0 && mid_ff == '0), "clear did not restore span")
   `SNL_ASSERT(a_mid_inside_span, (low_ff <= high_ff) |-> (mid_ff >= low_ff && mid_ff <= high_ff), "midpoint outside span")
   `SNL_ASSERT(a_led_holds_idle, (!light_req.update && !light_req.clear) |=> $stable(led_ff), "LED moved without a sample")

endmodule
`default_nettype wire

// ===== hdl/strobe_nibble_link_light_level_core.sv =====
`default_nettype none
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | op, strobe_level, bus_nibble, adc_sample
// rsp     | out       | rsp_valid/rsp_stall | led_on, bus_drive, bus_out, command_valid,
//         |           |                     | command, flush_queue
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Every request gives one response, one request per cycle while req_stall is low; the
// response is registered and shown from the output register.
// A two-entry output (register plus skid) lets a request enter while a response waits;
// req_stall rises only when the skid entry is full.
// Reset is synchronous; registers return to their reset values, but for the output and skid data.
// csr_ready is always high; writes to unknown indexes are dropped.
module strobe_nibble_link_light_level_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_op,
   input  wire logic                          req_strobe_level,
   input  wire logic [snl_pkg::NIBBLE_W-1:0]  req_bus_nibble,
   input  wire logic [snl_pkg::LEVEL_W-1:0]   req_adc_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_led_on,
   output logic                               rsp_bus_drive,
   output logic [snl_pkg::NIBBLE_W-1:0]       rsp_bus_out,
   output logic                               rsp_command_valid,
   output logic [snl_pkg::NIBBLE_W-1:0]       rsp_command,
   output logic                               rsp_flush_queue,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [snl_pkg::OFFSET_W-1:0]  csr_data
);
   import snl_pkg::*;
   `include "assert_macros.svh"

   logic [OFFSET_W-1:0] hyst_ff;
   logic [NIBBLE_W-1:0] get_ff;
   logic [NIBBLE_W-1:0] ack_ff;

   phase_type           phase_ff, phase_in;
   logic [NIBBLE_W-1:0] held_ff, held_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                drive_en_ff, drive_en_in;
   logic [NIBBLE_W-1:0] drive_val_ff, drive_val_in;

   result_type          out_ff, out_in, skid_ff, skid_in, result;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   logic                accept, rsp_pop, edge_ok, is_get, led_next;
   logic                cmd_valid;
   logic [NIBBLE_W-1:0] cmd_value;
   light_req_type       light_req;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_pop   = out_valid_ff && !rsp_stall;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff <= HYST_RESET;
         get_ff  <= GET_RESET;
         ack_ff  <= ACK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HYST: hyst_ff <= csr_data;
            CSR_GET:  get_ff  <= csr_data[NIBBLE_W-1:0];
            CSR_ACK:  ack_ff  <= csr_data[NIBBLE_W-1:0];
            default:  ;
         endcase
      end
   end

   // Step the bus phase on a strobe edge of the right level
   assign edge_ok = accept && (req_op == OP_STROBE) && (req_strobe_level == !phase_ff[0]);
   assign is_get  = (held_ff == get_ff);

   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      drive_en_in  = drive_en_ff;
      drive_val_in = drive_val_ff;
      cmd_valid    = 1'b0;
      cmd_value    = '0;
      if (accept && (req_op == OP_CLEAR)) begin
         phase_in = PH_WAIT_CMD;
      end else if (edge_ok) begin
         case (phase_ff)
            PH_WAIT_CMD: begin
               held_in  = req_bus_nibble;
               phase_in = PH_ANSWER;
            end
            PH_ANSWER: begin
               if (is_get) begin
                  drive_val_in = {2'b00, level_ff[9:8]};
               end else begin
                  cmd_valid    = 1'b1;
                  cmd_value    = held_ff;
                  drive_val_in = ack_ff;
               end
               drive_en_in = 1'b1;
               phase_in    = PH_SETTLE_A;
            end
            PH_SEND_MID: begin
               if (is_get) begin
                  drive_val_in = level_ff[7:4];
                  phase_in     = PH_SETTLE_B;
               end else begin
                  drive_en_in = 1'b0;
                  phase_in    = PH_WAIT_CMD;
               end
            end
            PH_SEND_LOW: begin
               drive_val_in = level_ff[3:0];
               phase_in     = PH_SETTLE_C;
            end
            PH_SEND_ACK: begin
               drive_val_in = ack_ff;
               phase_in     = PH_SETTLE_D;
            end
            PH_RELEASE: begin
               drive_en_in = 1'b0;
               phase_in    = PH_WAIT_CMD;
            end
            PH_SETTLE_A: phase_in = PH_SEND_MID;
            PH_SETTLE_B: phase_in = PH_SEND_LOW;
            PH_SETTLE_C: phase_in = PH_SEND_ACK;
            PH_SETTLE_D: phase_in = PH_RELEASE;
            default:     phase_in = PH_WAIT_CMD;
         endcase
      end
   end

   // Latch the latest light level
   assign level_in = (accept && (req_op == OP_SAMPLE)) ? req_adc_sample : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT_CMD;
         held_ff      <= '0;
         level_ff     <= '0;
         drive_en_ff  <= 1'b0;
         drive_val_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         level_ff     <= level_in;
         drive_en_ff  <= drive_en_in;
         drive_val_ff <= drive_val_in;
      end
   end

   // Light tracker
   assign light_req.update = accept && (req_op == OP_SAMPLE);
   assign light_req.clear  = accept && (req_op == OP_CLEAR);
   assign light_req.sample = req_adc_sample;

   snl_light u_light (
      .clock       (clock),
      .reset       (reset),
      .light_req   (light_req),
      .hyst_offset (hyst_ff),
      .led_next    (led_next)
   );

   // Build the response from the updated state
   always_comb begin
      result.led_on        = led_next;
      result.bus_drive     = drive_en_in;
      result.bus_out       = drive_en_in ? drive_val_in : '0;
      result.command_valid = cmd_valid;
      result.command       = cmd_value;
      result.flush_queue   = accept && (req_op == OP_CLEAR);
   end

   // Output register with one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_led_on        = out_ff.led_on;
   assign rsp_bus_drive     = out_ff.bus_drive;
   assign rsp_bus_out       = out_ff.bus_out;
   assign rsp_command_valid = out_ff.command_valid;
   assign rsp_command       = out_ff.command;
   assign rsp_flush_queue   = out_ff.flush_queue;

   `SNL_ASSERT(a_skid_needs_out, skid_valid_ff |-> out_valid_ff, "skid entry filled while output empty")
   `SNL_ASSERT(a_skid_drains, (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff, "skid entry did not drain")
   `SNL_ASSERT(a_command_acked, (rsp_valid && rsp_command_valid) |-> (rsp_bus_drive && rsp_bus_out == ack_ff), "handed-on command without acknowledge")
   `SNL_ASSERT_ALWAYS(a_reset_empties, reset |=> (!out_valid_ff && !skid_valid_ff), "output not empty after reset")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import snl_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_SPARE  = 2'd3;
   localparam int         IDLE_LIMIT = 4000;
   localparam int         PHASES     = 6;
   localparam int         PHASE_REQS = 86;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_op;
   logic                req_strobe_level;
   logic [NIBBLE_W-1:0] req_bus_nibble;
   logic [LEVEL_W-1:0]  req_adc_sample;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_led_on;
   logic                rsp_bus_drive;
   logic [NIBBLE_W-1:0] rsp_bus_out;
   logic                rsp_command_valid;
   logic [NIBBLE_W-1:0] rsp_command;
   logic                rsp_flush_queue;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [OFFSET_W-1:0] csr_data;

   result_type rsp_seen;

   strobe_nibble_link_light_level_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_strobe_level  (req_strobe_level),
      .req_bus_nibble    (req_bus_nibble),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_bus_drive     (rsp_bus_drive),
      .rsp_bus_out       (rsp_bus_out),
      .rsp_command_valid (rsp_command_valid),
      .rsp_command       (rsp_command),
      .rsp_flush_queue   (rsp_flush_queue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   assign rsp_seen = {rsp_led_on, rsp_bus_drive, rsp_bus_out,
                      rsp_command_valid, rsp_command, rsp_flush_queue};

   // Tracks bus phase and light statistics, holds the responses still owed
   class light_link_scoreboard;
      logic [OFFSET_W-1:0] hyst;
      logic [3:0]          get_nibble;
      logic [3:0]          ack_nibble;
      phase_type           phase;
      logic [3:0]          held_cmd;
      logic [9:0]          light;
      logic [9:0]          level_hi;
      logic [9:0]          level_lo;
      logic [9:0]          midpoint;
      logic                led;
      logic                drive_en;
      logic [3:0]          drive_val;
      result_type          awaited_q[$];
      int failures, checked, requests, reads_done, commands_out, clears, led_changes;

      function new();
         hyst = HYST_RESET;
         get_nibble = GET_RESET;
         ack_nibble = ACK_RESET;
         phase = PH_WAIT_CMD;
         held_cmd = '0;
         light = '0;
         level_hi = '0;
         level_lo = LEVEL_MAX;
         midpoint = '0;
         led = 1'b0;
         drive_en = 1'b0;
         drive_val = '0;
         failures = 0;
         checked = 0;
         requests = 0;
         reads_done = 0;
         commands_out = 0;
         clears = 0;
         led_changes = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [OFFSET_W-1:0] data);
         case (idx)
            CSR_HYST: hyst = data;
            CSR_GET:  get_nibble = data[3:0];
            CSR_ACK:  ack_nibble = data[3:0];
            default: ;
         endcase
      endfunction

      // Advance the model by one request and queue the response it owes
      function void note_request(logic [1:0] op, logic lvl, logic [3:0] nib,
                                 logic [9:0] smp);
         result_type r;
         logic       is_get;
         logic       cv;
         logic [3:0] cmd;
         logic       flush;
         logic       was_led;
         int         sum;
         cv = 1'b0;
         cmd = '0;
         flush = 1'b0;
         was_led = led;
         requests++;
         case (op)
            OP_STROBE: begin
               // even steps count a high strobe, odd steps a low one
               if (lvl != phase[0]) begin
                  is_get = (held_cmd == get_nibble);
                  case (phase)
                     PH_WAIT_CMD: begin
                        held_cmd = nib;
                        phase = PH_ANSWER;
                     end
                     PH_ANSWER: begin
                        if (is_get) begin
                           drive_val = {2'b00, light[9:8]};
                        end else begin
                           cv = 1'b1;
                           cmd = held_cmd;
                           drive_val = ack_nibble;
                           commands_out++;
                        end
                        drive_en = 1'b1;
                        phase = PH_SETTLE_A;
                     end
                     PH_SEND_MID: begin
                        if (is_get) begin
                           drive_val = light[7:4];
                           phase = PH_SETTLE_B;
                        end else begin
                           drive_en = 1'b0;
                           phase = PH_WAIT_CMD;
                        end
                     end
                     PH_SEND_LOW: begin
                        drive_val = light[3:0];
                        phase = PH_SETTLE_C;
                     end
                     PH_SEND_ACK: begin
                        drive_val = ack_nibble;
                        phase = PH_SETTLE_D;
                     end
                     PH_RELEASE: begin
                        drive_en = 1'b0;
                        phase = PH_WAIT_CMD;
                        reads_done++;
                     end
                     PH_SETTLE_A: phase = PH_SEND_MID;
                     PH_SETTLE_B: phase = PH_SEND_LOW;
                     PH_SETTLE_C: phase = PH_SEND_ACK;
                     PH_SETTLE_D: phase = PH_RELEASE;
                     default:     phase = PH_WAIT_CMD;
                  endcase
               end
            end
            OP_SAMPLE: begin
               light = smp;
               if (smp > level_hi) begin
                  level_hi = smp;
                  sum = int'(level_hi) + int'(level_lo);
                  midpoint = 10'(sum >> 1);
               end
               if (smp < level_lo) begin
                  level_lo = smp;
                  sum = int'(level_hi) + int'(level_lo);
                  midpoint = 10'(sum >> 1);
               end
               // hysteresis compares are done at full width, no wrap
               if (led) begin
                  if (int'(smp) + int'(hyst) < int'(midpoint))
                     led = 1'b0;
               end else if (int'(smp) > int'(midpoint) + int'(hyst)) begin
                  led = 1'b1;
               end
            end
            OP_CLEAR: begin
               level_lo = LEVEL_MAX;
               level_hi = '0;
               midpoint = '0;
               phase = PH_WAIT_CMD;
               flush = 1'b1;
               clears++;
            end
            default: ;
         endcase
         if (led != was_led)
            led_changes++;
         r.led_on = led;
         r.bus_drive = drive_en;
         r.bus_out = drive_en ? drive_val : 4'h0;
         r.command_valid = cv;
         r.command = cv ? cmd : 4'h0;
         r.flush_queue = flush;
         awaited_q.push_back(r);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10)
            $display("ERROR: %s", msg);
      endfunction

      function string show(result_type r);
         return $sformatf("led=%b drive=%b out=%h cv=%b cmd=%h flush=%b",
                          r.led_on, r.bus_drive, r.bus_out, r.command_valid,
                          r.command, r.flush_queue);
      endfunction

      // Compare one response against the oldest one owed
      function void check_response(result_type got);
         result_type want;
         string      diffs;
         checked++;
         if (awaited_q.size() == 0) begin
            flag($sformatf("response with none owed: %s", show(got)));
            return;
         end
         want = awaited_q.pop_front();
         diffs = "";
         if (got.led_on !== want.led_on)               diffs = {diffs, " led_on"};
         if (got.bus_drive !== want.bus_drive)         diffs = {diffs, " bus_drive"};
         if (got.bus_out !== want.bus_out)             diffs = {diffs, " bus_out"};
         if (got.command_valid !== want.command_valid) diffs = {diffs, " command_valid"};
         if (got.command !== want.command)             diffs = {diffs, " command"};
         if (got.flush_queue !== want.flush_queue)     diffs = {diffs, " flush_queue"};
         if (diffs != "")
            flag($sformatf("response %0d differs in%s: expected %s, actual %s",
                           checked, diffs, show(want), show(got)));
      endfunction
   endclass

   light_link_scoreboard sb;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_op, req_strobe_level, req_bus_nibble, req_adc_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_seen);
      end
   end

   // Receiver stall pattern: free runs, light and heavy random stalls, solid holds
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 60);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall = 1'b0;
         1:       rsp_stall = ($urandom_range(0, 3) == 0);
         2:       rsp_stall = ($urandom_range(0, 3) != 0);
         default: rsp_stall = (stall_left > 4);
      endcase
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("ERROR: no progress for %0d cycles, %0d responses owed",
               IDLE_LIMIT, sb.awaited_q.size());
      $display("FAIL strobe_nibble_link_light_level_core");
      $finish;
   end

   // Present one request at a falling edge, hold until taken, then pace the sender
   task automatic send_request(input logic [1:0] op, input logic lvl,
                               input logic [3:0] nib, input logic [9:0] smp);
      req_op = op;
      req_strobe_level = lvl;
      req_bus_nibble = nib;
      req_adc_sample = smp;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(15, 40)) @(negedge clock);
         else
            repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // Hold the sender until every owed response has arrived
   task automatic drain();
      req_valid = 1'b0;
      while (sb.awaited_q.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [OFFSET_W-1:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      sb.write_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      logic [OFFSET_W-1:0] hyst_plan[PHASES];
      logic [3:0]          get_plan[PHASES];
      logic [3:0]          ack_plan[PHASES];
      logic [1:0]          op;
      logic                lvl;
      logic [3:0]          nib;
      logic [9:0]          smp;
      int                  done;
      int                  pick;
      int                  base;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_STROBE;
      req_strobe_level = 1'b0;
      req_bus_nibble = '0;
      req_adc_sample = '0;
      csr_valid = 1'b0;
      csr_index = CSR_HYST;
      csr_data = '0;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Swing the LED both ways, then load a level with distinct nibbles
      send_request(OP_SAMPLE, 1'b0, 4'h0, 10'd1023);
      send_request(OP_SAMPLE, 1'b0, 4'h0, 10'd0);
      send_request(OP_SAMPLE, 1'b0, 4'h0, 10'd1023);
      send_request(OP_SAMPLE, 1'b0, 4'h0, 10'd0);
      send_request(OP_SAMPLE, 1'b0, 4'h0, 10'h2BC);
      // Full light-level read, with one edge at the wrong strobe level
      send_request(OP_STROBE, 1'b1, GET_RESET, 10'd0);
      send_request(OP_STROBE, 1'b1, 4'hF, 10'd1023);
      for (int i = 0; i < 9; i++)
         send_request(OP_STROBE, (i % 2 == 1), 4'h0, 10'd0);
      // Other command: handed on and acknowledged
      send_request(OP_STROBE, 1'b1, 4'hF, 10'd0);
      send_request(OP_STROBE, 1'b0, 4'h0, 10'd0);
      send_request(OP_STROBE, 1'b1, 4'h0, 10'd0);
      send_request(OP_STROBE, 1'b0, 4'h0, 10'd0);
      send_request(OP_CLEAR, 1'b0, 4'h0, 10'd0);
      send_request(OP_UNUSED, 1'b1, 4'hF, 10'd1023);

      // Register settings per phase, extremes first
      hyst_plan = '{9'd0, 9'd511, 9'd255, 9'd1, 9'd0, 9'd0};
      get_plan  = '{4'h0, 4'hF, 4'hA, 4'h5, 4'h0, 4'h0};
      ack_plan  = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h0, 4'h0};
      for (int p = 4; p < PHASES; p++) begin
         hyst_plan[p] = 9'($urandom_range(0, 511));
         get_plan[p] = 4'($urandom_range(0, 15));
         ack_plan[p] = 4'($urandom_range(0, 15));
      end

      for (int p = 0; p < PHASES; p++) begin
         // registers change only with nothing in flight; the bus phase may be mid-read
         drain();
         write_register(CSR_HYST, hyst_plan[p]);
         write_register(CSR_GET, {5'($urandom_range(0, 31)), get_plan[p]});
         write_register(CSR_ACK, {5'($urandom_range(0, 31)), ack_plan[p]});
         if (p == 2)
            write_register(CSR_SPARE, 9'($urandom_range(0, 511)));

         done = 0;
         while (done < PHASE_REQS) begin
            pick = $urandom_range(0, 99);
            lvl = ~sb.phase[0];
            nib = 4'($urandom_range(0, 15));
            smp = 10'($urandom_range(0, 1023));
            if (pick < 65) begin
               // well-formed edge; often the read command when a command is due
               op = OP_STROBE;
               if (sb.phase == PH_WAIT_CMD && $urandom_range(0, 1) == 1)
                  nib = sb.get_nibble;
               done++;
            end else if (pick < 73) begin
               op = OP_STROBE;
               lvl = sb.phase[0];
            end else if (pick < 93) begin
               op = OP_SAMPLE;
               pick = $urandom_range(0, 9);
               if (pick < 2) begin
                  smp = pick[0] ? 10'd1023 : 10'd0;
               end else if (pick < 5) begin
                  // land right around either hysteresis boundary
                  base = int'(sb.midpoint) + int'($urandom_range(0, 4)) - 2;
                  if ($urandom_range(0, 1) == 1)
                     base = base + int'(sb.hyst);
                  else
                     base = base - int'(sb.hyst);
                  if (base < 0)
                     base = 0;
                  if (base > 1023)
                     base = 1023;
                  smp = 10'(base);
               end
               done++;
            end else if (pick < 97) begin
               op = OP_CLEAR;
               done++;
            end else begin
               op = OP_UNUSED;
               lvl = 1'($urandom_range(0, 1));
            end
            send_request(op, lvl, nib, smp);
         end
      end

      drain();
      repeat (4) @(negedge clock);

      $display("Run covered %0d requests: %0d light-level reads, %0d commands handed on,",
               sb.requests, sb.reads_done, sb.commands_out);
      $display("%0d clears, %0d LED changes, %0d register settings, %0d mismatches.",
               sb.clears, sb.led_changes, PHASES, sb.failures);
      if (sb.failures == 0 && sb.awaited_q.size() == 0)
         $display("PASS strobe_nibble_link_light_level_core");
      else
         $display("FAIL strobe_nibble_link_light_level_core");
      $finish;
   end

endmodule

// ===== strobe_nibble_link_light_level_core.f =====
+incdir+hdl
hdl/snl_pkg.sv
hdl/snl_light.sv
hdl/strobe_nibble_link_light_level_core.sv
tb/testbench.sv
